@@ src/ccsr_pkg.sv @@
// shared types and constants for the coo to csr converter
// no dependencies; used by ccsr_convert and coo_to_csr_converter_top
package ccsr_pkg;

    localparam int MAX_ROWS    = 256;
    localparam int MAX_ENTRIES = 1024;
    localparam int PTR_DEPTH   = MAX_ROWS + 1;
    localparam int PTR_AW      = $clog2(PTR_DEPTH);
    localparam int ENT_AW      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = 11;
    localparam int ROW_W       = 8;
    localparam int COL_W       = 8;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int NROWS_W     = 9;
    localparam int RIDX_W      = 11;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD     = 2'd0,
        REQ_CONVERT  = 2'd1,
        REQ_READ_PTR = 2'd2,
        REQ_READ_CSR = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_BAD_ROW   = 2'd2,
        STAT_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CONV
    } top_state_t;

    typedef enum logic [3:0] {
        CV_IDLE,
        CV_CLEAR,
        CV_CNT_RD,
        CV_CNT_PTR,
        CV_CNT_WR,
        CV_SUM_RD,
        CV_SUM_WR,
        CV_SUM_END,
        CV_SCT_RD,
        CV_SCT_PTR,
        CV_SCT_WR,
        CV_SHF_RD,
        CV_SHF_WR,
        CV_FILL,
        CV_DONE
    } cv_state_t;

    // memory commands issued by the convert sequencer
    typedef struct packed {
        logic              tri_rd_en;
        logic [ENT_AW-1:0] tri_rd_addr;
        logic              ptr_rd_en;
        logic [PTR_AW-1:0] ptr_rd_addr;
        logic              ptr_wr_en;
        logic [PTR_AW-1:0] ptr_wr_addr;
        logic [CNT_W-1:0]  ptr_wr_data;
        logic              csr_wr_en;
        logic [ENT_AW-1:0] csr_wr_addr;
    } mem_cmd_t;

endpackage

@@ src/ccsr_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module ccsr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while no read is issued
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/ccsr_convert.sv @@
// convert sequencer: clear, count, prefix sum, scatter, shift and fill passes
// depends on ccsr_pkg; drives the triple, pointer and csr rams through mem_cmd_t
module ccsr_convert (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ccsr_pkg::PTR_AW-1:0]  rows,
    input  logic [ccsr_pkg::CNT_W-1:0]   loaded_count,
    input  logic [ccsr_pkg::ROW_W-1:0]   tri_row,
    input  logic [ccsr_pkg::CNT_W-1:0]   ptr_rdata,
    output ccsr_pkg::mem_cmd_t           cmd,
    output logic                         done,
    output logic [ccsr_pkg::CNT_W-1:0]   placed
);

    ccsr_pkg::cv_state_t state_reg, state_next;
    logic [ccsr_pkg::CNT_W-1:0]  ent_reg, ent_next;
    logic [ccsr_pkg::PTR_AW-1:0] row_reg, row_next;
    logic [ccsr_pkg::CNT_W-1:0]  sum_reg, sum_next;
    logic [ccsr_pkg::CNT_W-1:0]  prev_reg, prev_next;

    logic [ccsr_pkg::PTR_AW-1:0] rows_last;
    logic [ccsr_pkg::PTR_AW-1:0] tri_row_addr;
    logic                        tri_row_ok;
    logic                        ent_end;

    assign rows_last    = rows - ccsr_pkg::PTR_AW'(1);
    assign tri_row_addr = ccsr_pkg::PTR_AW'(tri_row);
    assign tri_row_ok   = tri_row_addr < rows;
    assign ent_end      = ent_reg >= loaded_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ccsr_pkg::CV_IDLE;
            ent_reg   <= '0;
            row_reg   <= '0;
            sum_reg   <= '0;
            prev_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ent_reg   <= ent_next;
            row_reg   <= row_next;
            sum_reg   <= sum_next;
            prev_reg  <= prev_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ent_next   = ent_reg;
        row_next   = row_reg;
        sum_next   = sum_reg;
        prev_next  = prev_reg;
        cmd        = '0;
        done       = 1'b0;
        case (state_reg)
            ccsr_pkg::CV_IDLE: begin
                if (start) begin
                    row_next   = '0;
                    state_next = ccsr_pkg::CV_CLEAR;
                end
            end
            ccsr_pkg::CV_CLEAR: begin
                cmd.ptr_wr_en   = 1'b1;
                cmd.ptr_wr_addr = row_reg;
                cmd.ptr_wr_data = '0;
                if (row_reg == rows_last) begin
                    ent_next   = '0;
                    state_next = ccsr_pkg::CV_CNT_RD;
                end else begin
                    row_next = row_reg + ccsr_pkg::PTR_AW'(1);
                end
            end
            ccsr_pkg::CV_CNT_RD: begin
                if (ent_end) begin
                    row_next   = '0;
                    sum_next   = '0;
                    state_next = ccsr_pkg::CV_SUM_RD;
                end else begin
                    cmd.tri_rd_en   = 1'b1;
                    cmd.tri_rd_addr = ent_reg[ccsr_pkg::ENT_AW-1:0];
                    state_next      = ccsr_pkg::CV_CNT_PTR;
                end
            end
            ccsr_pkg::CV_CNT_PTR: begin
                // rows dropped by a smaller row count are skipped
                if (tri_row_ok) begin
                    cmd.ptr_rd_en   = 1'b1;
                    cmd.ptr_rd_addr = tri_row_addr;
                    state_next      = ccsr_pkg::CV_CNT_WR;
                end else begin
                    ent_next   = ent_reg + ccsr_pkg::CNT_W'(1);
                    state_next = ccsr_pkg::CV_CNT_RD;
                end
            end
            ccsr_pkg::CV_CNT_WR: begin
                cmd.ptr_wr_en   = 1'b1;
                cmd.ptr_wr_addr = tri_row_addr;
                cmd.ptr_wr_data = ptr_rdata + ccsr_pkg::CNT_W'(1);
                ent_next        = ent_reg + ccsr_pkg::CNT_W'(1);
                state_next      = ccsr_pkg::CV_CNT_RD;
            end
            ccsr_pkg::CV_SUM_RD: begin
                cmd.ptr_rd_en   = 1'b1;
                cmd.ptr_rd_addr = row_reg;
                state_next      = ccsr_pkg::CV_SUM_WR;
            end
            ccsr_pkg::CV_SUM_WR: begin
                cmd.ptr_wr_en   = 1'b1;
                cmd.ptr_wr_addr = row_reg;
                cmd.ptr_wr_data = sum_reg;
                sum_next        = sum_reg + ptr_rdata;
                if (row_reg == rows_last) begin
                    state_next = ccsr_pkg::CV_SUM_END;
                end else begin
                    row_next   = row_reg + ccsr_pkg::PTR_AW'(1);
                    state_next = ccsr_pkg::CV_SUM_RD;
                end
            end
            ccsr_pkg::CV_SUM_END: begin
                cmd.ptr_wr_en   = 1'b1;
                cmd.ptr_wr_addr = rows;
                cmd.ptr_wr_data = sum_reg;
                ent_next        = '0;
                state_next      = ccsr_pkg::CV_SCT_RD;
            end
            ccsr_pkg::CV_SCT_RD: begin
                if (ent_end) begin
                    row_next   = '0;
                    prev_next  = '0;
                    state_next = ccsr_pkg::CV_SHF_RD;
                end else begin
                    cmd.tri_rd_en   = 1'b1;
                    cmd.tri_rd_addr = ent_reg[ccsr_pkg::ENT_AW-1:0];
                    state_next      = ccsr_pkg::CV_SCT_PTR;
                end
            end
            ccsr_pkg::CV_SCT_PTR: begin
                if (tri_row_ok) begin
                    cmd.ptr_rd_en   = 1'b1;
                    cmd.ptr_rd_addr = tri_row_addr;
                    state_next      = ccsr_pkg::CV_SCT_WR;
                end else begin
                    ent_next   = ent_reg + ccsr_pkg::CNT_W'(1);
                    state_next = ccsr_pkg::CV_SCT_RD;
                end
            end
            ccsr_pkg::CV_SCT_WR: begin
                // triple word is still on the ram output, written as is
                cmd.csr_wr_en   = 1'b1;
                cmd.csr_wr_addr = ptr_rdata[ccsr_pkg::ENT_AW-1:0];
                cmd.ptr_wr_en   = 1'b1;
                cmd.ptr_wr_addr = tri_row_addr;
                cmd.ptr_wr_data = ptr_rdata + ccsr_pkg::CNT_W'(1);
                ent_next        = ent_reg + ccsr_pkg::CNT_W'(1);
                state_next      = ccsr_pkg::CV_SCT_RD;
            end
            ccsr_pkg::CV_SHF_RD: begin
                cmd.ptr_rd_en   = 1'b1;
                cmd.ptr_rd_addr = row_reg;
                state_next      = ccsr_pkg::CV_SHF_WR;
            end
            ccsr_pkg::CV_SHF_WR: begin
                // row end pointers move up by one row
                cmd.ptr_wr_en   = 1'b1;
                cmd.ptr_wr_addr = row_reg;
                cmd.ptr_wr_data = prev_reg;
                prev_next       = ptr_rdata;
                if (row_reg == rows_last) begin
                    row_next   = rows;
                    state_next = ccsr_pkg::CV_FILL;
                end else begin
                    row_next   = row_reg + ccsr_pkg::PTR_AW'(1);
                    state_next = ccsr_pkg::CV_SHF_RD;
                end
            end
            ccsr_pkg::CV_FILL: begin
                cmd.ptr_wr_en   = 1'b1;
                cmd.ptr_wr_addr = row_reg;
                cmd.ptr_wr_data = sum_reg;
                if (row_reg == ccsr_pkg::PTR_AW'(ccsr_pkg::MAX_ROWS)) begin
                    state_next = ccsr_pkg::CV_DONE;
                end else begin
                    row_next = row_reg + ccsr_pkg::PTR_AW'(1);
                end
            end
            ccsr_pkg::CV_DONE: begin
                done       = 1'b1;
                state_next = ccsr_pkg::CV_IDLE;
            end
            default: begin
                state_next = ccsr_pkg::CV_IDLE;
            end
        endcase
    end

    assign placed = sum_reg;

endmodule

@@ src/coo_to_csr_converter_top.sv @@
// coo to csr converter top level: request control, output register, rams
// depends on ccsr_pkg, ccsr_ram and ccsr_convert
//
//   channel  ports                                  direction  handshake
//   s_       req_type row_index col_index value      in         s_valid / s_ready
//            read_index
//   m_       status entry_total row_pointer          out        m_valid / m_ready
//            col_out value_out
//   cfg_     num_rows (cfg_wr_data)                  in         cfg_wr_en, no wait
//
// a load result goes straight into the output register; a row pointer or csr entry
// read goes through one ram read first; a convert runs its passes in turn through the single
// pointer ram port pair that the clear, count, sum, scatter, shift and fill passes share
// one word is worked on at a time; s_ready is low while a read or convert runs
// and while an unaccepted result sits in the output register
// reset (aresetn, synchronous) clears the count and convert flag; rams keep
// their contents and need no clearing pass
module coo_to_csr_converter_top #(
    parameter int VALUE_BITS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ccsr_pkg::NROWS_W-1:0]   cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ccsr_pkg::REQ_W-1:0]     s_req_type,
    input  logic [ccsr_pkg::ROW_W-1:0]     s_row_index,
    input  logic [ccsr_pkg::COL_W-1:0]     s_col_index,
    input  logic [63:0]                    s_value,
    input  logic [ccsr_pkg::RIDX_W-1:0]    s_read_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ccsr_pkg::STATUS_W-1:0]  m_status,
    output logic [ccsr_pkg::CNT_W-1:0]     m_entry_total,
    output logic [ccsr_pkg::CNT_W-1:0]     m_row_pointer,
    output logic [ccsr_pkg::COL_W-1:0]     m_col_out,
    output logic [63:0]                    m_value_out
);

    localparam int TRI_W = ccsr_pkg::ROW_W + ccsr_pkg::COL_W + VALUE_BITS;
    localparam int CSR_W = ccsr_pkg::COL_W + VALUE_BITS;

    ccsr_pkg::top_state_t state_reg, state_next;
    logic [ccsr_pkg::NROWS_W-1:0] num_rows_reg;
    logic [ccsr_pkg::CNT_W-1:0]   loaded_count_reg, loaded_count_next;
    logic                         conv_reg, conv_next;
    logic [ccsr_pkg::CNT_W-1:0]   placed_reg, placed_next;
    logic                         rd_err_reg, rd_err_next;
    logic                         rd_is_ptr_reg, rd_is_ptr_next;

    logic                          m_valid_reg, m_valid_next;
    logic [ccsr_pkg::STATUS_W-1:0] m_status_reg;
    logic [ccsr_pkg::CNT_W-1:0]    m_entry_total_reg;
    logic [ccsr_pkg::CNT_W-1:0]    m_row_pointer_reg;
    logic [ccsr_pkg::COL_W-1:0]    m_col_out_reg;
    logic [63:0]                   m_value_out_reg;

    logic                          out_load;
    ccsr_pkg::status_t             out_status;
    logic [ccsr_pkg::CNT_W-1:0]    out_total;
    logic [ccsr_pkg::CNT_W-1:0]    out_rp;
    logic [ccsr_pkg::COL_W-1:0]    out_col;
    logic [63:0]                   out_val;

    ccsr_pkg::req_t                req;
    logic                          accept;
    logic [ccsr_pkg::PTR_AW-1:0]   rows;
    logic [ccsr_pkg::CNT_W-1:0]    eff_count;
    logic                          load_row_ok;
    logic                          load_room;
    logic                          conv_start;
    logic                          tri_wr_en;
    logic                          host_ptr_rd;
    logic                          host_csr_rd;

    ccsr_pkg::mem_cmd_t            eng_cmd;
    logic                          eng_done;
    logic [ccsr_pkg::CNT_W-1:0]    eng_placed;

    logic [TRI_W-1:0]              tri_wr_data;
    logic [TRI_W-1:0]              tri_rd_data;
    logic [ccsr_pkg::CNT_W-1:0]    ptr_rd_data;
    logic                          ptr_rd_en;
    logic [ccsr_pkg::PTR_AW-1:0]   ptr_rd_addr;
    logic [CSR_W-1:0]              csr_rd_data;

    assign req         = ccsr_pkg::req_t'(s_req_type);
    assign s_ready     = (state_reg == ccsr_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept      = s_valid && s_ready;

    // row count in use is clamped to 1..MAX_ROWS
    always_comb begin
        if (num_rows_reg == '0) begin
            rows = ccsr_pkg::PTR_AW'(1);
        end else if (num_rows_reg > ccsr_pkg::NROWS_W'(ccsr_pkg::MAX_ROWS)) begin
            rows = ccsr_pkg::PTR_AW'(ccsr_pkg::MAX_ROWS);
        end else begin
            rows = ccsr_pkg::PTR_AW'(num_rows_reg);
        end
    end

    // a load after a convert starts a new matrix
    assign eff_count   = conv_reg ? '0 : loaded_count_reg;
    assign load_row_ok = ccsr_pkg::PTR_AW'(s_row_index) < rows;
    assign load_room   = eff_count < ccsr_pkg::CNT_W'(ccsr_pkg::MAX_ENTRIES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ccsr_pkg::ST_IDLE;
            num_rows_reg     <= ccsr_pkg::NROWS_W'(1);
            loaded_count_reg <= '0;
            conv_reg         <= 1'b0;
            placed_reg       <= '0;
            rd_err_reg       <= 1'b0;
            rd_is_ptr_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            if (cfg_wr_en) begin
                num_rows_reg <= cfg_wr_data;
            end
            loaded_count_reg <= loaded_count_next;
            conv_reg         <= conv_next;
            placed_reg       <= placed_next;
            rd_err_reg       <= rd_err_next;
            rd_is_ptr_reg    <= rd_is_ptr_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg      <= out_status;
            m_entry_total_reg <= out_total;
            m_row_pointer_reg <= out_rp;
            m_col_out_reg     <= out_col;
            m_value_out_reg   <= out_val;
        end
    end

    always_comb begin
        state_next        = state_reg;
        loaded_count_next = loaded_count_reg;
        conv_next         = conv_reg;
        placed_next       = placed_reg;
        rd_err_next       = rd_err_reg;
        rd_is_ptr_next    = rd_is_ptr_reg;
        conv_start        = 1'b0;
        tri_wr_en         = 1'b0;
        host_ptr_rd       = 1'b0;
        host_csr_rd       = 1'b0;
        out_load          = 1'b0;
        out_status        = ccsr_pkg::STAT_OK;
        out_rp            = '0;
        out_col           = '0;
        out_val           = '0;
        case (state_reg)
            ccsr_pkg::ST_IDLE: begin
                if (accept) begin
                    case (req)
                        ccsr_pkg::REQ_LOAD: begin
                            conv_next         = 1'b0;
                            loaded_count_next = eff_count;
                            out_load          = 1'b1;
                            if (!load_row_ok) begin
                                out_status = ccsr_pkg::STAT_BAD_ROW;
                            end else if (!load_room) begin
                                out_status = ccsr_pkg::STAT_FULL;
                            end else begin
                                tri_wr_en         = 1'b1;
                                loaded_count_next = eff_count + ccsr_pkg::CNT_W'(1);
                            end
                        end
                        ccsr_pkg::REQ_CONVERT: begin
                            conv_start = 1'b1;
                            state_next = ccsr_pkg::ST_CONV;
                        end
                        ccsr_pkg::REQ_READ_PTR: begin
                            host_ptr_rd    = 1'b1;
                            rd_is_ptr_next = 1'b1;
                            rd_err_next    = !conv_reg
                                || (s_read_index > ccsr_pkg::RIDX_W'(rows));
                            state_next     = ccsr_pkg::ST_READ;
                        end
                        ccsr_pkg::REQ_READ_CSR: begin
                            host_csr_rd    = 1'b1;
                            rd_is_ptr_next = 1'b0;
                            rd_err_next    = !conv_reg
                                || (s_read_index >= placed_reg)
                                || (s_read_index
                                    >= ccsr_pkg::RIDX_W'(ccsr_pkg::MAX_ENTRIES));
                            state_next     = ccsr_pkg::ST_READ;
                        end
                        default: begin
                            state_next = ccsr_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ccsr_pkg::ST_READ: begin
                out_load   = 1'b1;
                state_next = ccsr_pkg::ST_IDLE;
                if (rd_err_reg) begin
                    out_status = ccsr_pkg::STAT_BAD_INDEX;
                end else if (rd_is_ptr_reg) begin
                    out_rp = ptr_rd_data;
                end else begin
                    out_col = csr_rd_data[CSR_W-1:VALUE_BITS];
                    out_val = 64'(csr_rd_data[VALUE_BITS-1:0]);
                end
            end
            ccsr_pkg::ST_CONV: begin
                if (eng_done) begin
                    conv_next   = 1'b1;
                    placed_next = eng_placed;
                    out_load    = 1'b1;
                    state_next  = ccsr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ccsr_pkg::ST_IDLE;
            end
        endcase
        out_total = loaded_count_next;
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_total = m_entry_total_reg;
    assign m_row_pointer = m_row_pointer_reg;
    assign m_col_out     = m_col_out_reg;
    assign m_value_out   = m_value_out_reg;

    ccsr_convert u_convert (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (conv_start),
        .rows         (rows),
        .loaded_count (loaded_count_reg),
        .tri_row      (tri_rd_data[TRI_W-1:CSR_W]),
        .ptr_rdata    (ptr_rd_data),
        .cmd          (eng_cmd),
        .done         (eng_done),
        .placed       (eng_placed)
    );

    assign tri_wr_data = {s_row_index, s_col_index, s_value[VALUE_BITS-1:0]};

    ccsr_ram #(
        .WIDTH (TRI_W),
        .DEPTH (ccsr_pkg::MAX_ENTRIES)
    ) u_triple_ram (
        .aclk    (aclk),
        .wr_en   (tri_wr_en),
        .wr_addr (eff_count[ccsr_pkg::ENT_AW-1:0]),
        .wr_data (tri_wr_data),
        .rd_en   (eng_cmd.tri_rd_en),
        .rd_addr (eng_cmd.tri_rd_addr),
        .rd_data (tri_rd_data)
    );

    // host reads only happen while the sequencer is idle
    assign ptr_rd_en   = host_ptr_rd || eng_cmd.ptr_rd_en;
    assign ptr_rd_addr = host_ptr_rd ? s_read_index[ccsr_pkg::PTR_AW-1:0]
                                     : eng_cmd.ptr_rd_addr;

    ccsr_ram #(
        .WIDTH (ccsr_pkg::CNT_W),
        .DEPTH (ccsr_pkg::PTR_DEPTH)
    ) u_pointer_ram (
        .aclk    (aclk),
        .wr_en   (eng_cmd.ptr_wr_en),
        .wr_addr (eng_cmd.ptr_wr_addr),
        .wr_data (eng_cmd.ptr_wr_data),
        .rd_en   (ptr_rd_en),
        .rd_addr (ptr_rd_addr),
        .rd_data (ptr_rd_data)
    );

    ccsr_ram #(
        .WIDTH (CSR_W),
        .DEPTH (ccsr_pkg::MAX_ENTRIES)
    ) u_csr_ram (
        .aclk    (aclk),
        .wr_en   (eng_cmd.csr_wr_en),
        .wr_addr (eng_cmd.csr_wr_addr),
        .wr_data (tri_rd_data[CSR_W-1:0]),
        .rd_en   (host_csr_rd),
        .rd_addr (s_read_index[ccsr_pkg::ENT_AW-1:0]),
        .rd_data (csr_rd_data)
    );

endmodule
